// ===== rtl/core/frac_n_pll_word_builder_macros.svh =====
// assertion helpers shared by the word builder
`ifndef FRAC_N_PLL_WORD_BUILDER_MACROS_SVH
`define FRAC_N_PLL_WORD_BUILDER_MACROS_SVH

// same-cycle implication
`define FNWB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication
`define FNWB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/fnwb_pkg.sv =====
package fnwb_pkg;
	localparam int FREQ_W   = 23;
	localparam int WORD_W   = 32;
	localparam int NUM_W    = 3;
	localparam int SEL_W    = 3;
	localparam int PROD_W   = 23;
	localparam int SCALED_W = 18;
	localparam int INT_W    = 8;
	localparam int FRAC_W   = 10;
	localparam int MOD_W    = 10;
	localparam int Q5_W     = 8;
	localparam int Q25_W    = 6;

	localparam int SHIFT_MAX = 6;
	localparam int NUM_THR   = 6;
	localparam int NUM_IMAGES = 6;

	localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(35000);
	localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(4400000);

	localparam logic [FREQ_W-1:0] THR_KHZ [NUM_THR] = '{
		FREQ_W'(69000), FREQ_W'(138000), FREQ_W'(275000),
		FREQ_W'(550000), FREQ_W'(1100000), FREQ_W'(2200000)
	};

	localparam logic [WORD_W-1:0] DIV_CODE [SHIFT_MAX+1] = '{
		32'h00E0_0000, 32'h00D0_0000, 32'h00C0_0000, 32'h00B0_0000,
		32'h00A0_0000, 32'h0090_0000, 32'h0080_0000
	};

	// floor(x/25) = (x * RCP25) >> RCP_SH for x < 2^23
	localparam int RCP_SH = 28;
	localparam logic [23:0] RCP25   = 24'd10737419;
	localparam logic [18:0] RCP1000 = 19'd268436;
	localparam logic [7:0]  RCP5    = 8'd205;
	localparam logic [5:0]  RCP25S  = 6'd41;
	localparam int SMALL_SH = 10;

	localparam logic [WORD_W-1:0] R4_KEEP      = 32'h000F_FFFF;
	localparam logic [WORD_W-1:0] R0_INT_KEEP  = 32'h0000_7FFF;
	localparam logic [WORD_W-1:0] R0_FRAC_KEEP = 32'hEFFF_8007;
	localparam logic [WORD_W-1:0] R1_MOD_KEEP  = 32'h1FFF_E007;

	localparam logic [WORD_W-1:0] IMG_RESET [NUM_IMAGES] = '{
		32'h0040_0000, 32'h0800_8011, 32'h0000_4E42,
		32'h0000_04B3, 32'h00CC_803C, 32'h0058_0005
	};

	localparam int QDEPTH = 2; // power of two
	localparam int QA_W   = 1;
	localparam int QC_W   = 2;

	typedef struct packed {
		logic [SEL_W-1:0]  sel;
		logic [PROD_W-1:0] prod;
	} q_entry_t;

	typedef struct packed {
		logic [SEL_W-1:0]  sel;
		logic [INT_W-1:0]  intv;
		logic [FRAC_W-1:0] frac;
		logic [MOD_W-1:0]  mod_val;
	} calc_res_t;
endpackage

// ===== rtl/core/fnwb_front.sv =====
module fnwb_front (
	input  logic [fnwb_pkg::FREQ_W-1:0] frequency_khz,
	output fnwb_pkg::q_entry_t          entry
);
	import fnwb_pkg::*;

	logic [FREQ_W-1:0]           f_sat;
	logic [SEL_W-1:0]            sel;
	logic [FREQ_W+SHIFT_MAX-1:0] wide;

	always_comb begin
		if (frequency_khz < FREQ_MIN) begin
			f_sat = FREQ_MIN;
		end else if (frequency_khz > FREQ_MAX) begin
			f_sat = FREQ_MAX;
		end else begin
			f_sat = frequency_khz;
		end
		sel = '0;
		for (int i = 0; i < NUM_THR; i++) begin
			sel = sel + SEL_W'(f_sat >= THR_KHZ[i]);
		end
		wide = (FREQ_W+SHIFT_MAX)'(f_sat) << (SEL_W'(SHIFT_MAX) - sel);
		entry.sel  = sel;
		entry.prod = wide[PROD_W-1:0];
	end
endmodule

// ===== rtl/core/fnwb_queue.sv =====
`include "frac_n_pll_word_builder_macros.svh"

module fnwb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  fnwb_pkg::q_entry_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output fnwb_pkg::q_entry_t rd_data,
	output logic               not_empty
);
	import fnwb_pkg::*;

	q_entry_t        ent_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full      = (cnt_q == QC_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = ent_q[rd_ptr_q];
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(do_wr) - QC_W'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	`FNWB_ASSERT_IMP(a_q_count, clk, arst_n, 1'b1, cnt_q <= QC_W'(QDEPTH))
endmodule

// ===== rtl/core/fnwb_calc.sv =====
module fnwb_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  fnwb_pkg::q_entry_t  in_data,
	input  logic                in_valid,
	output logic                in_take,
	output fnwb_pkg::calc_res_t res,
	output logic                res_valid,
	input  logic                res_take
);
	import fnwb_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [SEL_W-1:0]    sel_s1, sel_s2, sel_s3, sel_s4;
	logic [SCALED_W-1:0] scaled_s1, scaled_s2;
	logic [INT_W-1:0]    intv_s2, intv_s3, intv_s4;
	logic [FRAC_W-1:0]   frc_s3, frc_s4;
	logic [Q5_W-1:0]     q5_s4;
	logic [Q25_W-1:0]    q25_s4;
	calc_res_t           res_s5;

	logic [PROD_W+24-1:0]   p25;
	logic [SCALED_W+19-1:0] p1000;
	logic [SCALED_W-1:0]    int_x1000;
	logic [SCALED_W-1:0]    rem;
	logic [FRAC_W+8-1:0]    p5;
	logic [FRAC_W+6-1:0]    p25s;
	logic [FRAC_W-1:0]      x5;
	logic [FRAC_W-1:0]      x25;
	logic                   div5, div25;
	calc_res_t              nxt;

	assign en        = !v_s5 || res_take;
	assign in_take   = en && in_valid;
	assign res_valid = v_s5;
	assign res       = res_s5;

	assign p25       = PROD_W'(in_data.prod) * RCP25;
	assign p1000     = scaled_s1 * RCP1000;
	assign int_x1000 = SCALED_W'(intv_s2) * SCALED_W'(1000);
	assign rem       = scaled_s2 - int_x1000;
	assign p5        = frc_s3 * RCP5;
	assign p25s      = frc_s3 * RCP25S;
	assign x5        = FRAC_W'(q5_s4) * FRAC_W'(5);
	assign x25       = FRAC_W'(q25_s4) * FRAC_W'(25);
	assign div5      = (x5 == frc_s4);
	assign div25     = (x25 == frc_s4);

	always_comb begin
		nxt.sel  = sel_s4;
		nxt.intv = intv_s4;
		if (frc_s4 == '0) begin
			nxt.frac    = '0;
			nxt.mod_val = MOD_W'(2);
		end else if (frc_s4[2:0] == 3'd0 && div25) begin
			nxt.frac    = FRAC_W'(q25_s4 >> 3);
			nxt.mod_val = MOD_W'(5);
		end else if (frc_s4[2:0] == 3'd0 && div5) begin
			nxt.frac    = FRAC_W'(q5_s4 >> 3);
			nxt.mod_val = MOD_W'(25);
		end else if (frc_s4[1:0] == 2'd0 && div5) begin
			nxt.frac    = FRAC_W'(q5_s4 >> 2);
			nxt.mod_val = MOD_W'(50);
		end else if (frc_s4[2:0] == 3'd0) begin
			nxt.frac    = frc_s4 >> 3;
			nxt.mod_val = MOD_W'(125);
		end else if (frc_s4[1:0] == 2'd0) begin
			nxt.frac    = frc_s4 >> 2;
			nxt.mod_val = MOD_W'(250);
		end else if (frc_s4[0] == 1'b0) begin
			nxt.frac    = frc_s4 >> 1;
			nxt.mod_val = MOD_W'(500);
		end else begin
			nxt.frac    = frc_s4;
			nxt.mod_val = MOD_W'(1000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1    <= in_data.sel;
			scaled_s1 <= p25[RCP_SH+SCALED_W-1:RCP_SH];
			sel_s2    <= sel_s1;
			scaled_s2 <= scaled_s1;
			intv_s2   <= p1000[RCP_SH+INT_W-1:RCP_SH];
			intv_s3   <= intv_s2;
			sel_s3    <= sel_s2;
			frc_s3    <= rem[FRAC_W-1:0];
			sel_s4    <= sel_s3;
			intv_s4   <= intv_s3;
			frc_s4    <= frc_s3;
			q5_s4     <= p5[SMALL_SH+Q5_W-1:SMALL_SH];
			q25_s4    <= p25s[SMALL_SH+Q25_W-1:SMALL_SH];
			res_s5    <= nxt;
		end
	end
endmodule

// ===== rtl/core/fnwb_emit.sv =====
`include "frac_n_pll_word_builder_macros.svh"

module fnwb_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fnwb_pkg::calc_res_t         res,
	input  logic                        res_valid,
	output logic                        res_take,
	output logic [fnwb_pkg::WORD_W-1:0] reg_word,
	output logic [fnwb_pkg::NUM_W-1:0]  reg_number,
	output logic                        last_word,
	output logic                        empty,
	input  logic                        pop
);
	import fnwb_pkg::*;

	logic [WORD_W-1:0] img_q [NUM_IMAGES];
	logic              busy_q;
	logic [NUM_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] reg_word_q;
	logic [NUM_W-1:0]  reg_number_q;
	logic              last_word_q;
	logic              advance;
	logic [WORD_W-1:0] r0_int;

	assign advance    = !out_valid_q || pop;
	assign res_take   = res_valid && (!busy_q || (advance && idx_q == '0));
	assign empty      = !out_valid_q;
	assign reg_word   = reg_word_q;
	assign reg_number = reg_number_q;
	assign last_word  = last_word_q;
	assign r0_int     = (img_q[0] & R0_INT_KEEP) | (WORD_W'(res.intv) << 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IMAGES; i++) begin
				img_q[i] <= IMG_RESET[i];
			end
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				img_q[4] <= (img_q[4] & R4_KEEP) | DIV_CODE[res.sel];
				img_q[0] <= (r0_int & R0_FRAC_KEEP) | (WORD_W'(res.frac) << 3);
				img_q[1] <= (img_q[1] & R1_MOD_KEEP) | (WORD_W'(res.mod_val) << 3);
				busy_q   <= 1'b1;
				idx_q    <= NUM_W'(NUM_IMAGES - 1);
			end else if (advance && busy_q) begin
				idx_q <= idx_q - 1'b1;
				if (idx_q == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			reg_word_q   <= img_q[idx_q];
			reg_number_q <= idx_q;
			last_word_q  <= (idx_q == '0);
		end
	end

	`FNWB_ASSERT_NXT(a_busy_fills_out, clk, arst_n, busy_q && advance, out_valid_q)
	`FNWB_ASSERT_IMP(a_take_at_end, clk, arst_n, res_take, !busy_q || idx_q == '0)
	`FNWB_ASSERT_NXT(a_word_order, clk, arst_n, out_valid_q && pop && reg_number_q != '0,
		out_valid_q && reg_number_q == $past(reg_number_q) - 1'b1)
endmodule

// ===== rtl/core/frac_n_pll_word_builder.sv =====
// Fractional-N synthesizer register word builder.
// Input channel: frequency_khz is taken when push is high and full is low.
// Each input beat yields six result beats: register images R5 down to R0,
// reg_word with its reg_number, last_word set on R0.
// Result channel: a beat is shown while empty is low and leaves when pop is high.
// Throughput: set by the single output port that sends one 32-bit word per
// cycle while pop is high; the input queue (2 deep) and the 5-stage
// arithmetic pipeline fill up behind it.
// Reset: arst_n clears the queue, pipeline and output; the six images return
// to their default words.
// When pop stays low, the output word holds, the images freeze after at most
// one more result, the pipeline and queue stall and full rises once the
// queue is filled; no beat is lost.
module frac_n_pll_word_builder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [fnwb_pkg::FREQ_W-1:0] frequency_khz,
	output logic                        empty,
	input  logic                        pop,
	output logic [fnwb_pkg::WORD_W-1:0] reg_word,
	output logic [fnwb_pkg::NUM_W-1:0]  reg_number,
	output logic                        last_word
);
	import fnwb_pkg::*;

	q_entry_t  front_entry;
	q_entry_t  q_data;
	logic      q_not_empty;
	logic      q_take;
	calc_res_t calc_res;
	logic      calc_valid;
	logic      calc_take;

	fnwb_front u_front (
		.frequency_khz (frequency_khz),
		.entry         (front_entry)
	);

	fnwb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (front_entry),
		.full      (full),
		.rd_en     (q_take),
		.rd_data   (q_data),
		.not_empty (q_not_empty)
	);

	fnwb_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (q_data),
		.in_valid  (q_not_empty),
		.in_take   (q_take),
		.res       (calc_res),
		.res_valid (calc_valid),
		.res_take  (calc_take)
	);

	fnwb_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (calc_res),
		.res_valid  (calc_valid),
		.res_take   (calc_take),
		.reg_word   (reg_word),
		.reg_number (reg_number),
		.last_word  (last_word),
		.empty      (empty),
		.pop        (pop)
	);
endmodule

// ===== bench/frac_n_pll_word_builder_test.sv =====
module frac_n_pll_word_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FW = fnwb_pkg::FREQ_W;
	localparam int WW = fnwb_pkg::WORD_W;
	localparam int NW = fnwb_pkg::NUM_W;

	localparam int unsigned F_LO = 35000;
	localparam int unsigned F_HI = 4400000;
	localparam int unsigned BAND_EDGE [6] = '{69000, 138000, 275000, 550000, 1100000, 2200000};
	localparam int NUM_MODS = 9;
	localparam int unsigned MOD_STEP [NUM_MODS] = '{5, 25, 50, 125, 250, 500, 1000, 2000, 4000};
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [WW-1:0] word;
		logic [NW-1:0] num;
		logic          last;
	} reg_beat_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          push = 1'b0;
	logic          full;
	logic [FW-1:0] frequency_khz = '0;
	logic          empty;
	logic          pop = 1'b0;
	logic [WW-1:0] reg_word;
	logic [NW-1:0] reg_number;
	logic          last_word;

	logic [31:0] images [6];
	reg_beat_t   pending_words [$];
	reg_beat_t   want;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          stall_left = 0;

	frac_n_pll_word_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frequency_khz(frequency_khz),
		.empty(empty),
		.pop(pop),
		.reg_word(reg_word),
		.reg_number(reg_number),
		.last_word(last_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			pop <= 1'b0;
			stall_left = $urandom_range(12, 1) - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic note_mismatch(input string msg);
		if (mismatches < 10)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_words.size() == 0) begin
				note_mismatch($sformatf("unexpected beat word=%08h num=%0d last=%0b",
					reg_word, reg_number, last_word));
			end else begin
				want = pending_words.pop_front();
				if (reg_word !== want.word || reg_number !== want.num ||
						last_word !== want.last)
					note_mismatch($sformatf(
						"exp word=%08h num=%0d last=%0b, got word=%08h num=%0d last=%0b",
						want.word, want.num, want.last, reg_word, reg_number, last_word));
			end
		end
	end

	task automatic reset_images();
		images[0] = 32'h0040_0000;
		images[1] = 32'h0800_8011;
		images[2] = 32'h0000_4E42;
		images[3] = 32'h0000_04B3;
		images[4] = 32'h00CC_803C;
		images[5] = 32'h0058_0005;
	endtask

	task automatic predict_words(input logic [FW-1:0] f_in);
		longint unsigned f, scaled, intv, fracd, p;
		int sel;
		logic [31:0] frac_v, mod_v;
		reg_beat_t b;
		f = f_in;
		if (f < F_LO) f = F_LO;
		if (f > F_HI) f = F_HI;
		sel = 6;
		for (int i = 5; i >= 0; i--)
			if (f < BAND_EDGE[i]) sel = i;
		images[4] = (images[4] & 32'h000F_FFFF) | (32'h00E0_0000 - (32'(sel) << 20));
		scaled = (f * (64 >> sel)) / 25;
		intv = (scaled / 1000) % 10000;
		fracd = scaled % 1000;
		images[0] = (images[0] & 32'h0000_7FFF) | 32'(intv << 15);
		frac_v = 0;
		mod_v = 2;
		// lowest qualifying modulus wins
		if (fracd != 0)
			for (int i = NUM_MODS - 1; i >= 0; i--) begin
				p = MOD_STEP[i] * fracd;
				if (p % 1000 == 0) begin
					frac_v = 32'(p / 1000);
					mod_v = MOD_STEP[i];
				end
			end
		images[0] = (images[0] & 32'hEFFF_8007) | (frac_v << 3);
		images[1] = (images[1] & 32'h1FFF_E007) | (mod_v << 3);
		for (int r = 5; r >= 0; r--) begin
			b.word = images[r];
			b.num = NW'(r);
			b.last = (r == 0);
			pending_words.push_back(b);
		end
	endtask

	task automatic send_freq(input logic [FW-1:0] f);
		int gap;
		push <= 1'b1;
		frequency_khz <= f;
		do @(posedge clk); while (full);
		predict_words(f);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(12, 1);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [FW-1:0] pick_freq();
		int r;
		int unsigned v;
		r = $urandom_range(99);
		if (r < 15)
			v = $urandom_range(32'h7F_FFFF, 0);
		else if (r < 45)
			// divide-by-one band, fraction of N spread over every modulus
			v = 25 * $urandom_range(176000, 88000) + $urandom_range(24, 0);
		else if (r < 60)
			v = BAND_EDGE[$urandom_range(5, 0)] + $urandom_range(6, 0) - 3;
		else
			v = $urandom_range(F_HI, F_LO);
		return FW'(v);
	endfunction

	task automatic test_range_limits();
		logic [FW-1:0] vals [6] = '{0, 34999, 35000, 4400000, 4400001, 23'h7F_FFFF};
		gap_pct = 20;
		stall_pct = 20;
		foreach (vals[i]) send_freq(vals[i]);
	endtask

	task automatic test_divider_bands();
		gap_pct = 30;
		stall_pct = 10;
		foreach (BAND_EDGE[i]) begin
			send_freq(FW'(BAND_EDGE[i] - 1));
			send_freq(FW'(BAND_EDGE[i]));
		end
	endtask

	task automatic test_modulus_choice();
		logic [FW-1:0] vals [7] = '{2505000, 2501000, 2500500, 2500200, 2500100,
			2500050, 2500025};
		gap_pct = 10;
		stall_pct = 30;
		foreach (vals[i]) send_freq(vals[i]);
	endtask

	task automatic test_random_mix();
		int pct [3] = '{0, 20, 50};
		for (int n = 0; n < 175; n++) begin
			if (n % 40 == 0) begin
				gap_pct = pct[$urandom_range(2)];
				stall_pct = pct[$urandom_range(2)];
			end
			send_freq(pick_freq());
		end
	endtask

	task automatic test_back_to_back();
		gap_pct = 0;
		stall_pct = 0;
		for (int n = 0; n < 60; n++) send_freq(pick_freq());
	endtask

	initial begin
		reset_images();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_range_limits();
		test_divider_bands();
		test_modulus_choice();
		test_random_mix();
		test_back_to_back();
		push <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fnwb_pkg.sv
rtl/core/fnwb_front.sv
rtl/core/fnwb_queue.sv
rtl/core/fnwb_calc.sv
rtl/core/fnwb_emit.sv
rtl/core/frac_n_pll_word_builder.sv
bench/frac_n_pll_word_builder_test.sv
